@@ hdl/rrts_pkg.sv @@
// Package for the round-robin task scheduler.
// Holds the command and status codes and the fixed field widths.
// No dependencies; used by the channel interfaces and the top level.
package rrts_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int TAG_W    = 8;

  // Commands carried by an input item
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NEWRUN = 2'd3;

  // Status codes carried by a result item
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_BURST = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IDLE_RUN   = 3'd4;

endpackage

@@ hdl/rrts_req_if.sv @@
// Command channel of the round-robin task scheduler.
// Carries valid/ready and the command item; depends on rrts_pkg.
interface rrts_req_if #(
  parameter int BURST_BITS = 8
);
  logic                        valid;
  logic                        ready;
  logic [rrts_pkg::CMD_W-1:0]  cmd;
  logic [BURST_BITS-1:0]       burst;
  logic [rrts_pkg::TAG_W-1:0]  task_id;

  modport source (output valid, output cmd, output burst, output task_id, input ready);
  modport sink   (input valid, input cmd, input burst, input task_id, output ready);
endinterface

@@ hdl/rrts_rsp_if.sv @@
// Result channel of the round-robin task scheduler.
// Carries valid/ready and the result item; depends on rrts_pkg.
interface rrts_rsp_if #(
  parameter int BURST_BITS = 8,
  parameter int TIME_BITS  = 16
);
  logic                           valid;
  logic                           ready;
  logic [rrts_pkg::STATUS_W-1:0]  status;
  logic [rrts_pkg::TAG_W-1:0]     task_tag;
  logic [BURST_BITS-1:0]          remaining;
  logic                           finished;
  logic [TIME_BITS-1:0]           finish_time;
  logic                           all_done;

  modport source (output valid, output status, output task_tag, output remaining,
                  output finished, output finish_time, output all_done, input ready);
  modport sink   (input valid, input status, input task_tag, input remaining,
                  input finished, input finish_time, input all_done, output ready);
endinterface

@@ hdl/round_robin_task_scheduler.sv @@
// Round-robin task scheduler: task table in one slot memory (registered read).
// An add goes straight to its result; remove, tick and new run walk the table
// when it is not empty, through the single read port. One item at a time: a new
// command is taken only in the idle state. Reset (synchronous) empties
// the table and clears timer, position and id counter; no clearing pass.
module round_robin_task_scheduler #(
  parameter int MAX_TASKS  = 16,
  parameter int BURST_BITS = 8,
  parameter int TIME_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  rrts_req_if.sink    req,
  rrts_rsp_if.source  rsp
);

  localparam int IDXW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNTW = $clog2(MAX_TASKS + 1);
  localparam int WW   = (TIME_BITS > BURST_BITS) ? TIME_BITS : BURST_BITS;
  localparam int TAGW = rrts_pkg::TAG_W;
  localparam int STW  = rrts_pkg::STATUS_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIND   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_RUN    = 3'd4;
  localparam logic [2:0] S_RELOAD = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  typedef struct packed {
    logic [TAGW-1:0]       ident;
    logic [BURST_BITS-1:0] rem;
    logic [TIME_BITS-1:0]  exec;
    logic [TIME_BITS-1:0]  finish;
  } slot_t;

  // Slot memory
  slot_t slot_mem [MAX_TASKS];

  logic [2:0]            state;
  logic [CNTW-1:0]       entry_count;
  logic [CNTW-1:0]       done_count;
  logic [IDXW-1:0]       pos;
  logic [TIME_BITS-1:0]  run_timer;
  logic [TAGW-1:0]       next_ident;
  logic [TAGW-1:0]       tid;

  // Table walk
  logic [IDXW-1:0]       scan_addr;
  logic [CNTW-1:0]       scan_left;
  logic [CNTW-1:0]       chk_left;
  logic                  rvalid;
  logic [IDXW-1:0]       ridx;
  slot_t                 rdata;
  logic [IDXW-1:0]       found;
  logic [IDXW-1:0]       pick_idx;
  slot_t                 pick_data;

  // Pending result
  logic [STW-1:0]        res_status;
  logic [TAGW-1:0]       res_tag;
  logic [BURST_BITS-1:0] res_rem;
  logic                  res_fin;
  logic [TIME_BITS-1:0]  res_ftime;

  // Output register
  logic                  ovalid;
  logic [STW-1:0]        o_status;
  logic [TAGW-1:0]       o_tag;
  logic [BURST_BITS-1:0] o_rem;
  logic                  o_fin;
  logic [TIME_BITS-1:0]  o_ftime;
  logic                  o_all_done;

  logic                  accept;
  logic                  issue;
  logic                  hit;
  logic                  emit_now;
  logic [IDXW-1:0]       addr_inc;
  logic [IDXW-1:0]       start_pos;
  logic [IDXW-1:0]       fin_idx;
  logic [IDXW-1:0]       pos_dec;
  logic [CNTW-1:0]       cnt_dec;
  logic [IDXW-1:0]       pos_after;
  logic [BURST_BITS-1:0] run_rem;
  logic [TIME_BITS-1:0]  run_exec;
  logic                  run_fin;
  logic [WW-1:0]         exec_w;
  logic [BURST_BITS-1:0] reload_rem;
  logic                  mem_we;
  logic [IDXW-1:0]       mem_waddr;
  slot_t                 mem_wdata;

  assign req.ready       = (state == S_IDLE);
  assign accept          = req.valid && req.ready;
  assign rsp.valid       = ovalid;
  assign rsp.status      = o_status;
  assign rsp.task_tag    = o_tag;
  assign rsp.remaining   = o_rem;
  assign rsp.finished    = o_fin;
  assign rsp.finish_time = o_ftime;
  assign rsp.all_done    = o_all_done;

  // Walk control and position arithmetic
  always_comb begin
    issue     = (scan_left != '0) &&
                (state == S_FIND || state == S_SHIFT || state == S_SCAN || state == S_RELOAD);
    addr_inc  = ((CNTW'(scan_addr) + CNTW'(1)) >= entry_count) ? '0 : scan_addr + IDXW'(1);
    start_pos = (CNTW'(pos) < entry_count) ? pos : '0;
    hit       = rvalid && (((state == S_FIND) && (rdata.ident == tid)) ||
                           ((state == S_SCAN) && (rdata.rem != '0)));
    emit_now  = (state == S_EMIT) && (!ovalid || rsp.ready);
    fin_idx   = (state == S_FIND) ? ridx : found;
    pos_dec   = (fin_idx < pos) ? pos - IDXW'(1) : pos;
    cnt_dec   = entry_count - CNTW'(1);
    pos_after = (CNTW'(pos_dec) >= cnt_dec) ? '0 : pos_dec;
  end

  // Per-slot update for a tick and for a reload
  always_comb begin
    run_rem    = pick_data.rem - BURST_BITS'(1);
    run_exec   = (&pick_data.exec) ? pick_data.exec : pick_data.exec + TIME_BITS'(1);
    run_fin    = (run_rem == '0);
    exec_w     = WW'(rdata.exec);
    reload_rem = (exec_w > WW'({BURST_BITS{1'b1}})) ? {BURST_BITS{1'b1}}
                                                    : BURST_BITS'(exec_w);
  end

  // Memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rdata;
    if (accept && (req.cmd == rrts_pkg::CMD_ADD) && (req.burst != '0) &&
        (entry_count < CNTW'(MAX_TASKS))) begin
      mem_we           = 1'b1;
      mem_waddr        = IDXW'(entry_count);
      mem_wdata.ident  = next_ident;
      mem_wdata.rem    = req.burst;
      mem_wdata.exec   = '0;
      mem_wdata.finish = '0;
    end else if ((state == S_SHIFT) && rvalid) begin
      mem_we    = 1'b1;
      mem_waddr = ridx - IDXW'(1);
    end else if ((state == S_RELOAD) && rvalid) begin
      mem_we           = 1'b1;
      mem_waddr        = ridx;
      mem_wdata.rem    = reload_rem;
      mem_wdata.finish = '0;
    end else if (state == S_RUN) begin
      mem_we           = 1'b1;
      mem_waddr        = pick_idx;
      mem_wdata        = pick_data;
      mem_wdata.rem    = run_rem;
      mem_wdata.exec   = run_exec;
      mem_wdata.finish = run_fin ? run_timer : pick_data.finish;
    end
  end

  // Memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rdata <= slot_mem[scan_addr];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      done_count  <= '0;
      pos         <= '0;
      run_timer   <= '0;
      next_ident  <= '0;
      scan_left   <= '0;
      chk_left    <= '0;
      rvalid      <= 1'b0;
      ovalid      <= 1'b0;
    end else begin
      // advance the table walk; a hit stops it and the state sets the next walk
      rvalid <= issue && !hit;
      ridx   <= scan_addr;
      if (issue && !hit) begin
        scan_addr <= addr_inc;
        scan_left <= scan_left - CNTW'(1);
      end
      if (rvalid && !hit) begin
        chk_left <= chk_left - CNTW'(1);
      end

      // load the output item from the emit state, drop it once taken
      if (emit_now) begin
        ovalid <= 1'b1;
      end else if (ovalid && rsp.ready) begin
        ovalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            tid       <= req.task_id;
            res_rem   <= '0;
            res_fin   <= 1'b0;
            res_ftime <= '0;
            unique case (req.cmd)
              rrts_pkg::CMD_ADD: begin
                state <= S_EMIT;
                if (req.burst == '0) begin
                  res_status <= rrts_pkg::ST_ZERO_BURST;
                  res_tag    <= '0;
                end else if (entry_count >= CNTW'(MAX_TASKS)) begin
                  res_status <= rrts_pkg::ST_FULL;
                  res_tag    <= '0;
                end else begin
                  res_status  <= rrts_pkg::ST_OK;
                  res_tag     <= next_ident;
                  entry_count <= entry_count + CNTW'(1);
                  next_ident  <= next_ident + TAGW'(1);
                end
              end
              rrts_pkg::CMD_REMOVE: begin
                res_tag <= req.task_id;
                if (entry_count == '0) begin
                  res_status <= rrts_pkg::ST_NOT_FOUND;
                  state      <= S_EMIT;
                end else begin
                  res_status <= rrts_pkg::ST_OK;
                  scan_addr  <= '0;
                  scan_left  <= entry_count;
                  chk_left   <= entry_count;
                  state      <= S_FIND;
                end
              end
              rrts_pkg::CMD_TICK: begin
                res_tag <= '0;
                if (entry_count == '0) begin
                  res_status <= rrts_pkg::ST_IDLE_RUN;
                  state      <= S_EMIT;
                end else begin
                  res_status <= rrts_pkg::ST_OK;
                  scan_addr  <= start_pos;
                  scan_left  <= entry_count;
                  chk_left   <= entry_count;
                  state      <= S_SCAN;
                end
              end
              rrts_pkg::CMD_NEWRUN: begin
                res_status <= rrts_pkg::ST_OK;
                res_tag    <= '0;
                done_count <= '0;
                run_timer  <= '0;
                pos        <= '0;
                if (entry_count == '0) begin
                  state <= S_EMIT;
                end else begin
                  scan_addr <= '0;
                  scan_left <= entry_count;
                  chk_left  <= entry_count;
                  state     <= S_RELOAD;
                end
              end
              default: begin
                res_status <= rrts_pkg::ST_OK;
                res_tag    <= '0;
                state      <= S_EMIT;
              end
            endcase
          end
        end

        S_FIND: begin
          if (hit) begin
            res_tag <= tid;
            found   <= ridx;
            if ((rdata.rem == '0) && (done_count != '0)) begin
              done_count <= done_count - CNTW'(1);
            end
            if ((CNTW'(ridx) + CNTW'(1)) < entry_count) begin
              // move the later entries down by one
              scan_addr <= ridx + IDXW'(1);
              scan_left <= entry_count - CNTW'(ridx) - CNTW'(1);
              chk_left  <= entry_count - CNTW'(ridx) - CNTW'(1);
              state     <= S_SHIFT;
            end else begin
              scan_left   <= '0;
              entry_count <= cnt_dec;
              pos         <= pos_after;
              state       <= S_EMIT;
            end
          end else if (rvalid && (chk_left == CNTW'(1))) begin
            res_status <= rrts_pkg::ST_NOT_FOUND;
            res_tag    <= tid;
            scan_left  <= '0;
            state      <= S_EMIT;
          end
        end

        S_SHIFT: begin
          if (rvalid && (chk_left == CNTW'(1))) begin
            entry_count <= cnt_dec;
            pos         <= pos_after;
            state       <= S_EMIT;
          end
        end

        S_SCAN: begin
          if (hit) begin
            pick_idx  <= ridx;
            pick_data <= rdata;
            scan_left <= '0;
            state     <= S_RUN;
          end else if (rvalid && (chk_left == CNTW'(1))) begin
            res_status <= rrts_pkg::ST_IDLE_RUN;
            scan_left  <= '0;
            state      <= S_EMIT;
          end
        end

        S_RUN: begin
          res_tag   <= pick_data.ident;
          res_rem   <= run_rem;
          res_fin   <= run_fin;
          res_ftime <= run_fin ? run_timer : '0;
          if (run_fin) begin
            done_count <= done_count + CNTW'(1);
          end
          run_timer <= run_timer + TIME_BITS'(1);
          pos       <= ((CNTW'(pick_idx) + CNTW'(1)) < entry_count) ?
                       pick_idx + IDXW'(1) : '0;
          state     <= S_EMIT;
        end

        S_RELOAD: begin
          if (rvalid) begin
            if (reload_rem == '0) begin
              done_count <= done_count + CNTW'(1);
            end
            if (chk_left == CNTW'(1)) begin
              state <= S_EMIT;
            end
          end
        end

        S_EMIT: begin
          // hold until the output register is free
          if (emit_now) begin
            o_status   <= res_status;
            o_tag      <= res_tag;
            o_rem      <= res_rem;
            o_fin      <= res_fin;
            o_ftime    <= res_ftime;
            o_all_done <= (done_count == entry_count);
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_done_le_count: assert property (@(posedge clk) disable iff (rst)
    done_count <= entry_count)
    else $error("finished count exceeds table size");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNTW'(MAX_TASKS))
    else $error("table size beyond capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && issue) |-> (mem_waddr != scan_addr))
    else $error("read and write of the same slot in one cycle");

  a_rvalid_walk: assert property (@(posedge clk) disable iff (rst)
    rvalid |-> (state == S_FIND || state == S_SHIFT || state == S_SCAN ||
                state == S_RELOAD))
    else $error("read data outside a table walk");

  a_idle_no_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (scan_left == '0) && !rvalid)
    else $error("table walk still active when idle");

endmodule
